// ===== rtl/linked_list_queue_manager_top_assert.svh =====
// Assertion macros for the queue manager checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LINKED_LIST_QUEUE_MANAGER_TOP_ASSERT_SVH
`define LINKED_LIST_QUEUE_MANAGER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LLQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue manager check failed");

// Next-cycle implication, checked outside reset.
`define LLQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue manager check failed");

`endif

// ===== rtl/llq_pkg.sv =====
// Shared constants, codes and types of the linked list queue manager.
// No dependencies; every other file but the assertion macros header depends on it.
package llq_pkg;

    localparam int ITEMS  = 16;
    localparam int IDXW   = $clog2(ITEMS);
    localparam int LINKW  = $clog2(ITEMS + 1);
    localparam int LENW   = $clog2(ITEMS + 1);
    localparam int ACT_W  = 3;
    localparam int ITEM_W = 4;
    localparam int QLEN_W = 5;

    // A link that holds this value marks the end of the list.
    localparam logic [LINKW-1:0]  END_MARK   = LINKW'(ITEMS);
    localparam logic [ITEM_W:0]   ITEM_LIMIT = (ITEM_W + 1)'(ITEMS);

    typedef enum logic [ACT_W-1:0] {
        ACT_PUT    = 3'd0,
        ACT_PUSH   = 3'd1,
        ACT_GET    = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_QUERY  = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_WALK,
        ST_INS_LINK,
        ST_INS_FIN,
        ST_UNLINK_RD,
        ST_UNLINK_WR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic walk_step;
        logic rd_unlink;
        logic tail_link;
        logic ins_fin;
        logic unlink_fin;
        logic set_hit;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    in_pool;
        logic    len_zero;
        logic    walk_done;
        logic    walk_match;
        logic    out_free;
    } dp_stat_t;

endpackage

// ===== rtl/llq_req_if.sv =====
// Request channel: valid/ready handshake carrying action and item index.
// Depends on llq_pkg for the field widths.
interface llq_req_if;
    logic                        valid;
    logic                        ready;
    logic [llq_pkg::ACT_W-1:0]   action;
    logic [llq_pkg::ITEM_W-1:0]  item;

    modport source (output valid, output action, output item, input ready);
    modport sink   (input valid, input action, input item, output ready);
endinterface

// ===== rtl/llq_rsp_if.sv =====
// Response channel: valid/ready handshake carrying a result item, a hit flag and the queue length.
// Depends on llq_pkg for the field widths.
interface llq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [llq_pkg::ITEM_W-1:0]  result_item;
    logic                        hit;
    logic [llq_pkg::QLEN_W-1:0]  queue_length;

    modport source (output valid, output result_item, output hit, output queue_length,
                    input ready);
    modport sink   (input valid, input result_item, input hit, input queue_length,
                    output ready);
endinterface

// ===== rtl/linked_list_queue_manager_top.sv =====
// A rejected request goes from dispatch straight to the response; get unlinks the head
// without a walk, while put, push, remove and query first walk the list one link per cycle
// through the single read port of the link memory. Requests are taken one at a time; the
// next is taken in the cycle after the result is loaded into the output register.
// Reset (asynchronous, active low) empties the queue; the link memory is not cleared.
module linked_list_queue_manager_top (
    input  logic       clk,
    input  logic       rst_n,
    llq_req_if.sink    req,
    llq_rsp_if.source  rsp
);
    import llq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     idle;
    logic     start;

    assign req.ready = idle;
    assign start     = req.valid && idle;

    llq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .idle  (idle),
        .cmd   (cmd),
        .stat  (stat)
    );

    llq_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .action           (req.action),
        .item             (req.item),
        .cmd              (cmd),
        .stat             (stat),
        .out_ready        (rsp.ready),
        .out_valid        (rsp.valid),
        .out_result_item  (rsp.result_item),
        .out_hit          (rsp.hit),
        .out_queue_length (rsp.queue_length)
    );

endmodule

// ===== rtl/llq_ctrl.sv =====
// Controller state machine of the queue manager.
// Depends on llq_pkg; drives llq_dpath through dp_cmd_t and reads dp_stat_t.
module llq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              idle,
    output llq_pkg::dp_cmd_t  cmd,
    input  llq_pkg::dp_stat_t stat
);
    import llq_pkg::*;

    state_t state_reg;
    state_t state_next;

    assign idle = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (stat.action)
                    ACT_PUT, ACT_PUSH, ACT_REMOVE, ACT_QUERY:
                        state_next = stat.in_pool ? ST_WALK : ST_RESP;
                    ACT_GET:
                        state_next = stat.len_zero ? ST_RESP : ST_UNLINK_RD;
                    default:
                        state_next = ST_RESP;
                endcase
            end
            ST_WALK:
            begin
                if (stat.walk_done)
                begin
                    // The item is not in the queue.
                    case (stat.action)
                        ACT_PUT:  state_next = stat.len_zero ? ST_INS_FIN : ST_INS_LINK;
                        ACT_PUSH: state_next = ST_INS_FIN;
                        default:  state_next = ST_RESP;
                    endcase
                end
                else if (stat.walk_match)
                begin
                    case (stat.action)
                        ACT_QUERY:
                        begin
                            cmd.set_hit = 1'b1;
                            state_next  = ST_RESP;
                        end
                        ACT_REMOVE: state_next = ST_UNLINK_RD;
                        default:    state_next = ST_RESP;
                    endcase
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_INS_LINK:
            begin
                cmd.tail_link = 1'b1;
                state_next    = ST_INS_FIN;
            end
            ST_INS_FIN:
            begin
                cmd.ins_fin = 1'b1;
                state_next  = ST_RESP;
            end
            ST_UNLINK_RD:
            begin
                cmd.rd_unlink = 1'b1;
                state_next    = ST_UNLINK_WR;
            end
            ST_UNLINK_WR:
            begin
                cmd.unlink_fin = 1'b1;
                state_next     = ST_RESP;
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/llq_dpath.sv =====
// Datapath of the queue manager: head, tail and length registers, the link
// memory, the list walker and the output register. Depends on llq_pkg.
module llq_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [llq_pkg::ACT_W-1:0]   action,
    input  logic [llq_pkg::ITEM_W-1:0]  item,
    input  llq_pkg::dp_cmd_t            cmd,
    output llq_pkg::dp_stat_t           stat,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [llq_pkg::ITEM_W-1:0]  out_result_item,
    output logic                        out_hit,
    output logic [llq_pkg::QLEN_W-1:0]  out_queue_length
);
    import llq_pkg::*;

    logic [LINKW-1:0]  link_mem [ITEMS];

    action_t           action_reg;
    logic [ITEM_W-1:0] item_reg;
    logic [IDXW-1:0]   head_reg;
    logic [IDXW-1:0]   tail_reg;
    logic [LENW-1:0]   len_reg;
    logic [LENW-1:0]   cnt_reg;
    logic [IDXW-1:0]   prev_reg;
    logic [ITEM_W-1:0] res_item_reg;
    logic              hit_reg;
    logic [LINKW-1:0]  rd_data_reg;
    logic              out_valid_reg;
    logic [ITEM_W-1:0] out_item_reg;
    logic              out_hit_reg;
    logic [QLEN_W-1:0] out_len_reg;

    logic [IDXW-1:0]   item_idx;
    logic [IDXW-1:0]   cur_idx;
    logic [IDXW-1:0]   target_idx;
    logic [IDXW-1:0]   rd_addr;
    logic              end_hit;
    logic              at_head;
    logic              len_zero;
    logic [LENW-1:0]   len_inc;
    logic [LENW-1:0]   len_dec;
    logic              wr_en;
    logic [IDXW-1:0]   wr_addr;
    logic [LINKW-1:0]  wr_data;

    assign item_idx = item_reg[IDXW-1:0];
    // The first element of a walk is the head; later ones come from the link read.
    assign at_head  = (cnt_reg == '0);
    assign cur_idx  = at_head ? head_reg : rd_data_reg[IDXW-1:0];
    assign end_hit  = !at_head && (rd_data_reg >= END_MARK);
    assign len_zero = (len_reg == '0);
    assign len_inc  = len_reg + LENW'(1);
    assign len_dec  = len_reg - LENW'(1);

    assign target_idx = (action_reg == ACT_GET) ? head_reg : item_idx;
    assign rd_addr    = cmd.rd_unlink ? target_idx : cur_idx;

    assign stat.action     = action_reg;
    assign stat.in_pool    = ({1'b0, item_reg} < ITEM_LIMIT);
    assign stat.len_zero   = len_zero;
    assign stat.walk_done  = (cnt_reg == len_reg) || end_hit;
    assign stat.walk_match = (cur_idx == item_idx);
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = tail_reg;
        wr_data = LINKW'(item_idx);
        if (cmd.tail_link)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.ins_fin)
        begin
            wr_en   = 1'b1;
            wr_addr = item_idx;
            wr_data = ((action_reg == ACT_PUT) || len_zero) ? END_MARK : LINKW'(head_reg);
        end
        else if (cmd.unlink_fin && !at_head)
        begin
            // Bridge the predecessor over the removed item.
            wr_en   = 1'b1;
            wr_addr = prev_reg;
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= link_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            len_reg  <= '0;
        end
        else if (cmd.ins_fin)
        begin
            len_reg <= len_inc;
            if (action_reg == ACT_PUT)
            begin
                tail_reg <= item_idx;
                if (len_zero)
                begin
                    head_reg <= item_idx;
                end
            end
            else
            begin
                head_reg <= item_idx;
                if (len_zero)
                begin
                    tail_reg <= item_idx;
                end
            end
        end
        else if (cmd.unlink_fin)
        begin
            len_reg <= len_dec;
            if (len_dec == '0)
            begin
                head_reg <= '0;
                tail_reg <= '0;
            end
            else if (at_head)
            begin
                head_reg <= rd_data_reg[IDXW-1:0];
            end
            else if (tail_reg == item_idx)
            begin
                tail_reg <= prev_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg   <= action_t'(action);
            item_reg     <= item;
            cnt_reg      <= '0;
            res_item_reg <= item;
            hit_reg      <= 1'b0;
        end
        if (cmd.walk_step)
        begin
            prev_reg <= cur_idx;
            cnt_reg  <= cnt_reg + LENW'(1);
        end
        if (cmd.set_hit || cmd.ins_fin)
        begin
            hit_reg <= 1'b1;
        end
        if (cmd.unlink_fin)
        begin
            hit_reg <= 1'b1;
            if (action_reg == ACT_GET)
            begin
                res_item_reg <= ITEM_W'(head_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_item_reg <= res_item_reg;
            out_hit_reg  <= hit_reg;
            out_len_reg  <= QLEN_W'(len_reg);
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_result_item  = out_item_reg;
    assign out_hit          = out_hit_reg;
    assign out_queue_length = out_len_reg;

endmodule

// ===== rtl/llq_checker.sv =====
// Port-level checker for the queue manager, bound to the top level.
// Depends on llq_pkg and the assertion macros header.
`include "linked_list_queue_manager_top_assert.svh"

module llq_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [llq_pkg::ITEM_W-1:0]  rsp_result_item,
    input logic                        rsp_hit,
    input logic [llq_pkg::QLEN_W-1:0]  rsp_queue_length
);
    import llq_pkg::*;

    logic              req_fire;
    logic              rsp_fire;
    logic [QLEN_W-1:0] last_len_reg;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // Length reported by the last delivered item; the queue starts empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_len_reg <= '0;
        end
        else if (rsp_fire)
        begin
            last_len_reg <= rsp_queue_length;
        end
    end

    `LLQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_item) && $stable(rsp_hit) && $stable(rsp_queue_length))
    `LLQ_ASSERT_NEXT(a_busy_after_accept, req_fire, !req_ready)
    `LLQ_ASSERT_NOW(a_miss_keeps_length, rsp_fire && !rsp_hit, rsp_queue_length == last_len_reg)
    `LLQ_ASSERT_NOW(a_length_step, rsp_fire, rsp_queue_length == last_len_reg || rsp_queue_length == last_len_reg + QLEN_W'(1) || rsp_queue_length + QLEN_W'(1) == last_len_reg)

endmodule

bind linked_list_queue_manager_top llq_checker u_llq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_result_item  (rsp.result_item),
    .rsp_hit          (rsp.hit),
    .rsp_queue_length (rsp.queue_length)
);
